>>> rtl/fdme_pkg.sv
package fdme_pkg;

  localparam int WORD_W   = 64;
  localparam int COUNT_W  = 4;
  localparam int KIND_W   = 2;
  localparam int CMD_POS_W = 5;

  localparam logic [KIND_W-1:0] KIND_KEY   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_MASK  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DELTA = 2'd2;

  // One classified input word on its way from the front end to the back end.
  typedef struct packed {
    logic                 key;
    logic                 last;
    logic [CMD_POS_W-1:0] pos;
    logic [WORD_W-1:0]    word;
  } cmd_t;

endpackage

>>> rtl/fdme_front.sv
module fdme_front #(
  parameter int FRAME_BYTES = 256
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [fdme_pkg::WORD_W-1:0] frame_word_i,
  input  logic                        stream_start_i,
  output logic                        push_valid_o,
  input  logic                        push_ready_i,
  output fdme_pkg::cmd_t              push_cmd_o
);
  import fdme_pkg::*;

  localparam int FRAME_WORDS = FRAME_BYTES / 8;

  logic [CMD_POS_W-1:0] pos_q, pos_d;
  logic                 key_q, key_d;
  logic [CMD_POS_W-1:0] pos_c;
  logic                 key_c;
  logic                 last_c;
  logic                 accept;

  assign accept = in_valid_i && push_ready_i;

  // A stream start drops any partial frame and opens a keyframe at word 0.
  assign key_c  = stream_start_i | key_q;
  assign pos_c  = stream_start_i ? '0 : pos_q;
  assign last_c = (pos_c == CMD_POS_W'(FRAME_WORDS - 1));

  assign pos_d = last_c ? '0 : CMD_POS_W'(pos_c + 1'b1);
  assign key_d = key_c && !last_c;

  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i;

  always_comb begin
    push_cmd_o.key  = key_c;
    push_cmd_o.last = last_c;
    push_cmd_o.pos  = pos_c;
    push_cmd_o.word = frame_word_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      key_q <= 1'b1;
    end else if (accept) begin
      pos_q <= pos_d;
      key_q <= key_d;
    end
  end

endmodule

>>> rtl/fdme_queue.sv
module fdme_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  fdme_pkg::cmd_t push_cmd_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output fdme_pkg::cmd_t pop_cmd_o
);
  import fdme_pkg::*;

  localparam logic [1:0] DEPTH = 2'd2;

  cmd_t       entry_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign push_ready_o = (cnt_q != DEPTH);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_cmd_o    = entry_q[rptr_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) begin
        wptr_q <= ~wptr_q;
      end
      if (pop) begin
        rptr_q <= ~rptr_q;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_fill_tracks_push : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (cnt_q == $past(cnt_q) + 2'd1) && (cnt_q <= DEPTH))
    else $error("queue fill count lost a push");
`endif

endmodule

>>> rtl/fdme_back.sv
module fdme_back #(
  parameter int FRAME_BYTES = 256
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         pop_valid_i,
  output logic                         pop_ready_o,
  input  fdme_pkg::cmd_t               pop_cmd_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [fdme_pkg::WORD_W-1:0]  out_word_o,
  output logic [fdme_pkg::COUNT_W-1:0] byte_count_o,
  output logic [fdme_pkg::KIND_W-1:0]  word_kind_o,
  output logic                         last_of_run_o
);
  import fdme_pkg::*;

  localparam int FRAME_WORDS = FRAME_BYTES / 8;
  localparam int MASK_WORDS  = (FRAME_WORDS + 7) / 8;
  localparam int POS_W       = $clog2(FRAME_WORDS);
  localparam int TOTAL_W     = $clog2(FRAME_WORDS * 8 + 1);
  localparam int NW_W        = TOTAL_W - 2;
  localparam int MIDX_W      = (MASK_WORDS > 1) ? $clog2(MASK_WORDS) : 1;
  localparam logic [MIDX_W-1:0]  MASK_LAST     = MIDX_W'(MASK_WORDS - 1);
  localparam logic [COUNT_W-1:0] LAST_MASK_CNT = COUNT_W'(FRAME_WORDS - 8 * (MASK_WORDS - 1));
  localparam logic [COUNT_W-1:0] FULL_CNT      = COUNT_W'(8);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CMP  = 2'd1;
  localparam logic [1:0] ST_MASK = 2'd2;
  localparam logic [1:0] ST_DATA = 2'd3;

  logic [1:0]              state_q, state_d;
  cmd_t                    cmd_q;
  logic [WORD_W-1:0]       prev_mem [FRAME_WORDS];
  logic [WORD_W-1:0]       chg_mem  [FRAME_WORDS];
  logic [WORD_W-1:0]       prev_rd_q, chg_rd_q;
  logic [MASK_WORDS*64-1:0] mask_q;
  logic [TOTAL_W-1:0]      total_q, total_d;
  logic [WORD_W-1:0]       partial_q, partial_d;
  logic [MIDX_W-1:0]       m_q, m_d;
  logic [POS_W-1:0]        k_q, k_d;

  logic                    out_valid_q;
  logic [WORD_W-1:0]       out_word_q;
  logic [COUNT_W-1:0]      out_cnt_q;
  logic [KIND_W-1:0]       out_kind_q;
  logic                    out_last_q;

  logic                    load_ok, load;
  logic [WORD_W-1:0]       ld_word;
  logic [COUNT_W-1:0]      ld_cnt;
  logic [KIND_W-1:0]       ld_kind;
  logic                    ld_last;

  logic                    pop;
  logic                    prev_we;
  logic [POS_W-1:0]        prev_waddr;
  logic [WORD_W-1:0]       prev_wdata;
  logic                    chg_we;
  logic                    mask_we;

  logic [POS_W-1:0]        pos_c;
  logic                    first_c;
  logic [TOTAL_W-1:0]      base_total;
  logic [WORD_W-1:0]       partial_base;
  logic [7:0]              diff;
  logic [WORD_W-1:0]       compact;
  logic [3:0]              n_changed;
  logic [3:0]              fill_sum;
  logic [2*WORD_W-1:0]     combined;

  logic [NW_W-1:0]         full_nw, nwords, kx;
  logic [2:0]              rem;
  logic                    is_full, last_word;

  assign load_ok = !out_valid_q || out_ready_i;
  assign pop     = pop_valid_i && pop_ready_o;

  // Compare stage: previous bytes arrive from the registered store read.
  assign pos_c        = cmd_q.pos[POS_W-1:0];
  assign first_c      = (cmd_q.pos == '0);
  assign base_total   = first_c ? '0 : total_q;
  assign partial_base = first_c ? '0 : partial_q;

  always_comb begin
    for (int b = 0; b < 8; b++) begin
      diff[b] = (cmd_q.word[8*b +: 8] != prev_rd_q[8*b +: 8]);
    end
  end

  // Changed bytes are packed toward the low end in frame order.
  always_comb begin
    logic [3:0] idx;
    idx     = '0;
    compact = '0;
    for (int b = 0; b < 8; b++) begin
      if (diff[b]) begin
        compact[8*idx[2:0] +: 8] = cmd_q.word[8*b +: 8];
        idx = idx + 4'd1;
      end
    end
    n_changed = idx;
  end

  assign fill_sum = {1'b0, base_total[2:0]} + n_changed;
  assign combined = {{WORD_W{1'b0}}, partial_base}
                  | ({{WORD_W{1'b0}}, compact} << {base_total[2:0], 3'b000});

  // Emission of the changed bytes: whole words from the store, the tail from partial_q.
  assign rem       = total_q[2:0];
  assign full_nw   = NW_W'(total_q[TOTAL_W-1:3]);
  assign nwords    = full_nw + NW_W'(rem != 3'd0);
  assign kx        = NW_W'(k_q);
  assign is_full   = (kx < full_nw);
  assign last_word = ((kx + NW_W'(1)) == nwords);

  always_comb begin
    state_d     = state_q;
    pop_ready_o = 1'b0;
    prev_we     = 1'b0;
    prev_waddr  = pop_cmd_i.pos[POS_W-1:0];
    prev_wdata  = pop_cmd_i.word;
    chg_we      = 1'b0;
    mask_we     = 1'b0;
    total_d     = total_q;
    partial_d   = partial_q;
    m_d         = m_q;
    k_d         = k_q;
    load        = 1'b0;
    ld_word     = pop_cmd_i.word;
    ld_cnt      = FULL_CNT;
    ld_kind     = KIND_KEY;
    ld_last     = 1'b1;

    case (state_q)
      ST_IDLE: begin
        pop_ready_o = !pop_cmd_i.key || load_ok;
        if (pop) begin
          if (pop_cmd_i.key) begin
            prev_we = 1'b1;
            load    = 1'b1;
          end else begin
            state_d = ST_CMP;
          end
        end
      end
      ST_CMP: begin
        prev_we    = 1'b1;
        prev_waddr = pos_c;
        prev_wdata = cmd_q.word;
        mask_we    = 1'b1;
        chg_we     = fill_sum[3];
        total_d    = TOTAL_W'(base_total + TOTAL_W'(n_changed));
        partial_d  = fill_sum[3] ? combined[2*WORD_W-1:WORD_W] : combined[WORD_W-1:0];
        if (cmd_q.last) begin
          m_d     = '0;
          state_d = ST_MASK;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_MASK: begin
        k_d = '0;
        if (load_ok) begin
          load    = 1'b1;
          ld_word = mask_q[int'(m_q)*64 +: 64];
          ld_cnt  = (m_q == MASK_LAST) ? LAST_MASK_CNT : FULL_CNT;
          ld_kind = KIND_MASK;
          ld_last = (m_q == MASK_LAST) && (total_q == '0);
          if (m_q == MASK_LAST) begin
            state_d = (total_q == '0) ? ST_IDLE : ST_DATA;
          end else begin
            m_d = MIDX_W'(m_q + 1'b1);
          end
        end
      end
      ST_DATA: begin
        if (load_ok) begin
          load    = 1'b1;
          ld_word = is_full ? chg_rd_q : partial_q;
          ld_cnt  = is_full ? FULL_CNT : {1'b0, rem};
          ld_kind = KIND_DELTA;
          ld_last = last_word;
          k_d     = POS_W'(k_q + 1'b1);
          if (last_word) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (prev_we) begin
      prev_mem[prev_waddr] <= prev_wdata;
    end
    prev_rd_q <= prev_mem[pop_cmd_i.pos[POS_W-1:0]];
    if (chg_we) begin
      chg_mem[base_total[POS_W+2:3]] <= combined[WORD_W-1:0];
    end
    chg_rd_q <= chg_mem[k_d];
    if (pop) begin
      cmd_q <= pop_cmd_i;
    end
    partial_q <= partial_d;
    m_q       <= m_d;
    k_q       <= k_d;
    if (load) begin
      out_word_q <= ld_word;
      out_cnt_q  <= ld_cnt;
      out_kind_q <= ld_kind;
      out_last_q <= ld_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      total_q     <= '0;
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      total_q <= total_d;
      if (mask_we) begin
        mask_q[int'(pos_c)*8 +: 8] <= diff;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_word_o    = out_word_q;
  assign byte_count_o  = out_cnt_q;
  assign word_kind_o   = out_kind_q;
  assign last_of_run_o = out_last_q;

`ifndef ASSERT_OFF
  a_key_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_kind_q == KIND_KEY)) |-> (out_last_q && (out_cnt_q == FULL_CNT)))
    else $error("keyframe item must be a full word that closes its run");

  a_cmp_after_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CMP) |-> $past(state_q == ST_IDLE))
    else $error("compare step entered without a store read");

  a_total_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DATA) |->
      ((total_q <= TOTAL_W'(FRAME_WORDS * 8)) && (total_q != '0)))
    else $error("changed-byte count out of range during emission");
`endif

endmodule

>>> rtl/frame_delta_mask_encoder.sv
// Channel  Handshake                 Payload
// input    in_valid_i / in_ready_o   frame_word_i, stream_start_i
// output   out_valid_o / out_ready_i out_word_o, byte_count_o, word_kind_o, last_of_run_o
//
// A keyframe word yields one result.
// A delta word is handled as a registered read of the previous-frame store,
// then the compare that updates the mask, the changed-byte store and the frame store.
// The last word of a delta frame then emits ceil(FRAME_BYTES/64) mask words and
// ceil(changed/8) data words, one per cycle through the output register unless it stalls.
// Reset clears control state and the mask only; both byte stores are valid once written.
// A two-entry queue lets the input side run ahead while the back end stalls on output.
module frame_delta_mask_encoder #(
  parameter int FRAME_BYTES = 256
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [fdme_pkg::WORD_W-1:0]  frame_word_i,
  input  logic                         stream_start_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [fdme_pkg::WORD_W-1:0]  out_word_o,
  output logic [fdme_pkg::COUNT_W-1:0] byte_count_o,
  output logic [fdme_pkg::KIND_W-1:0]  word_kind_o,
  output logic                         last_of_run_o
);
  import fdme_pkg::*;

  logic push_valid, push_ready;
  cmd_t push_cmd;
  logic pop_valid, pop_ready;
  cmd_t pop_cmd;

  fdme_front #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .frame_word_i  (frame_word_i),
    .stream_start_i(stream_start_i),
    .push_valid_o  (push_valid),
    .push_ready_i  (push_ready),
    .push_cmd_o    (push_cmd)
  );

  fdme_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_cmd_i  (push_cmd),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_cmd_o   (pop_cmd)
  );

  fdme_back #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pop_valid_i  (pop_valid),
    .pop_ready_o  (pop_ready),
    .pop_cmd_i    (pop_cmd),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_word_o   (out_word_o),
    .byte_count_o (byte_count_o),
    .word_kind_o  (word_kind_o),
    .last_of_run_o(last_of_run_o)
  );

endmodule

>>> tb/tb_frame_delta_mask_encoder.sv
`timescale 1ns / 100ps

module tb_frame_delta_mask_encoder;
  import fdme_pkg::*;

  localparam int FRAME_BYTES  = 256;
  localparam int FRAME_WORDS  = FRAME_BYTES / 8;
  localparam int MASK_WORDS   = (FRAME_WORDS + 7) / 8;
  localparam int RAND_ITEMS   = 280;
  localparam int MIN_FRAMES   = 4;
  localparam int GAP_PCT      = 27;
  localparam int DRAIN_CYCLES = 40;
  localparam int SETTLE_LIMIT = 20000;
  localparam int RUN_LIMIT_NS = 2_000_000;
  localparam int DIR_ROWS     = 20;

  typedef struct packed {
    logic [WORD_W-1:0]  data;
    logic [COUNT_W-1:0] nbytes;
    logic [KIND_W-1:0]  kind;
    logic               tail;
  } enc_word_t;

  typedef struct packed {
    logic               start;
    logic [WORD_W-1:0]  word;
    logic [WORD_W-1:0]  want_data;
    logic [COUNT_W-1:0] want_nbytes;
    logic [KIND_W-1:0]  want_kind;
    logic               want_tail;
  } dir_row_t;

  typedef enum int {
    FM_SAME, FM_FLIP, FM_SPARSE, FM_NOISE, FM_RESTART, FM_BROKEN
  } frame_mode_e;

  logic              clk_i        = 1'b0;
  logic              rst_ni       = 1'b0;
  logic              in_valid     = 1'b0;
  logic [WORD_W-1:0] frame_word   = '0;
  logic              stream_start = 1'b0;
  logic              out_ready    = 1'b0;
  logic              in_ready;
  logic              out_valid;
  logic [WORD_W-1:0]  out_word;
  logic [COUNT_W-1:0] byte_count;
  logic [KIND_W-1:0]  word_kind;
  logic               last_of_run;

  // Encoder mirror: byte stores, mask and frame progress.
  logic [7:0]  frame_bytes [FRAME_BYTES];
  logic [7:0]  diff_bytes  [FRAME_BYTES];
  logic [63:0] mask_bits   [4];
  int unsigned frame_pos;
  int unsigned changed_cnt;
  bit          keyframe_on;
  int unsigned frames_closed = 0;

  enc_word_t step_results [$];
  enc_word_t expected_q   [$];
  enc_word_t head_word;
  int unsigned fail_cnt   = 0;
  bit          quiet_span = 1'b0;

  // Keyframe words right after reset pass straight through, restarts included.
  dir_row_t dir_tab [DIR_ROWS] = '{
    '{1'b0, 64'h0000000000000000, 64'h0000000000000000, 4'd8, KIND_KEY, 1'b1},
    '{1'b0, 64'hFFFFFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFF, 4'd8, KIND_KEY, 1'b1},
    '{1'b0, 64'h5555555555555555, 64'h5555555555555555, 4'd8, KIND_KEY, 1'b1},
    '{1'b0, 64'hAAAAAAAAAAAAAAAA, 64'hAAAAAAAAAAAAAAAA, 4'd8, KIND_KEY, 1'b1},
    '{1'b1, 64'h0123456789ABCDEF, 64'h0123456789ABCDEF, 4'd8, KIND_KEY, 1'b1},
    '{1'b0, 64'hFFFF0000FFFF0000, 64'hFFFF0000FFFF0000, 4'd8, KIND_KEY, 1'b1},
    '{1'b0, 64'h0000FFFF0000FFFF, 64'h0000FFFF0000FFFF, 4'd8, KIND_KEY, 1'b1},
    '{1'b1, 64'h8000000000000001, 64'h8000000000000001, 4'd8, KIND_KEY, 1'b1},
    '{1'b0, 64'h7FFFFFFFFFFFFFFE, 64'h7FFFFFFFFFFFFFFE, 4'd8, KIND_KEY, 1'b1},
    '{1'b0, 64'h00000000000000FF, 64'h00000000000000FF, 4'd8, KIND_KEY, 1'b1},
    '{1'b0, 64'hFF00000000000000, 64'hFF00000000000000, 4'd8, KIND_KEY, 1'b1},
    '{1'b0, 64'h0102040810204080, 64'h0102040810204080, 4'd8, KIND_KEY, 1'b1},
    '{1'b0, 64'h8040201008040201, 64'h8040201008040201, 4'd8, KIND_KEY, 1'b1},
    '{1'b0, 64'h13579BDF2468ACE0, 64'h13579BDF2468ACE0, 4'd8, KIND_KEY, 1'b1},
    '{1'b0, 64'hFEDCBA9876543210, 64'hFEDCBA9876543210, 4'd8, KIND_KEY, 1'b1},
    '{1'b1, 64'h00000000FFFFFFFF, 64'h00000000FFFFFFFF, 4'd8, KIND_KEY, 1'b1},
    '{1'b0, 64'hFFFFFFFF00000000, 64'hFFFFFFFF00000000, 4'd8, KIND_KEY, 1'b1},
    '{1'b0, 64'h0F0F0F0F0F0F0F0F, 64'h0F0F0F0F0F0F0F0F, 4'd8, KIND_KEY, 1'b1},
    '{1'b0, 64'hF0F0F0F0F0F0F0F0, 64'hF0F0F0F0F0F0F0F0, 4'd8, KIND_KEY, 1'b1},
    '{1'b0, 64'h0000000100000001, 64'h0000000100000001, 4'd8, KIND_KEY, 1'b1}
  };

  frame_delta_mask_encoder #(
    .FRAME_BYTES(FRAME_BYTES)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .frame_word_i  (frame_word),
    .stream_start_i(stream_start),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .out_word_o    (out_word),
    .byte_count_o  (byte_count),
    .word_kind_o   (word_kind),
    .last_of_run_o (last_of_run)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic void note_fail(string msg);
    fail_cnt++;
    if (fail_cnt <= 10) begin
      $display("%s", msg);
    end
  endfunction

  function automatic logic [WORD_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic void clear_frame();
    foreach (mask_bits[i]) mask_bits[i] = '0;
    changed_cnt = 0;
    frame_pos   = 0;
  endfunction

  // Works out the results one accepted input word causes and advances the mirror.
  function automatic void encode_word(logic [WORD_W-1:0] w, logic s);
    int unsigned idx;
    int unsigned left;
    int unsigned cnt;
    logic [7:0]  v;
    logic [WORD_W-1:0] pk;
    step_results.delete();
    if (s) begin
      clear_frame();
      keyframe_on = 1'b1;
    end
    if (keyframe_on) begin
      for (int b = 0; b < 8; b++) frame_bytes[frame_pos * 8 + b] = w[8 * b +: 8];
      step_results.push_back('{w, 4'd8, KIND_KEY, 1'b1});
      frame_pos++;
      if (frame_pos >= FRAME_WORDS) begin
        frame_pos   = 0;
        keyframe_on = 1'b0;
      end
      return;
    end
    for (int b = 0; b < 8; b++) begin
      idx = frame_pos * 8 + b;
      v   = w[8 * b +: 8];
      if (v != frame_bytes[idx]) begin
        mask_bits[idx / 64][idx % 64] = 1'b1;
        diff_bytes[changed_cnt] = v;
        changed_cnt++;
      end
      frame_bytes[idx] = v;
    end
    frame_pos++;
    if (frame_pos < FRAME_WORDS) begin
      return;
    end
    for (int m = 0; m < MASK_WORDS; m++) begin
      left = FRAME_WORDS - 8 * m;
      step_results.push_back('{mask_bits[m], COUNT_W'(left > 8 ? 8 : left), KIND_MASK, 1'b0});
    end
    for (int k = 0; k < changed_cnt; k += 8) begin
      left = changed_cnt - k;
      cnt  = left > 8 ? 8 : left;
      pk   = '0;
      for (int b = 0; b < cnt; b++) pk[8 * b +: 8] = diff_bytes[k + b];
      step_results.push_back('{pk, COUNT_W'(cnt), KIND_DELTA, 1'b0});
    end
    step_results[step_results.size() - 1].tail = 1'b1;
    frames_closed++;
    clear_frame();
  endfunction

  // Called and returns at a falling edge. A typed expectation replaces the mirror's.
  task automatic send_word(logic [WORD_W-1:0] w, logic s, bit typed, enc_word_t want);
    while (!quiet_span && $urandom_range(0, 99) < GAP_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid     <= 1'b1;
    frame_word   <= w;
    stream_start <= s;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    encode_word(w, s);
    if (typed) begin
      expected_q.push_back(want);
    end else begin
      foreach (step_results[k]) expected_q.push_back(step_results[k]);
    end
    @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    out_ready <= quiet_span || ($urandom_range(0, 99) >= GAP_PCT);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        note_fail($sformatf("unexpected result: data=%h nbytes=%0d kind=%0d tail=%b",
                            out_word, byte_count, word_kind, last_of_run));
      end else begin
        head_word = expected_q.pop_front();
        if (out_word !== head_word.data || byte_count !== head_word.nbytes ||
            word_kind !== head_word.kind || last_of_run !== head_word.tail) begin
          note_fail($sformatf({"result mismatch: want data=%h nbytes=%0d kind=%0d tail=%b",
                               " got data=%h nbytes=%0d kind=%0d tail=%b"},
                              head_word.data, head_word.nbytes, head_word.kind,
                              head_word.tail, out_word, byte_count, word_kind,
                              last_of_run));
        end
      end
    end
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("tb_frame_delta_mask_encoder: FAIL");
    $finish;
  end

  initial begin
    frame_mode_e       plan [5];
    frame_mode_e       mode;
    logic [WORD_W-1:0] word;
    logic [WORD_W-1:0] base;
    logic              start;
    int                rand_cnt;
    int                plan_idx;
    int                density;
    int                break_at;
    int                wait_cycles;
    int                pick;
    bit                drained;

    // The first delta frames cover no change, every byte changed, a few bytes
    // changed, a frame cut short by a new stream and a fresh stream.
    plan     = '{FM_SAME, FM_FLIP, FM_SPARSE, FM_BROKEN, FM_RESTART};
    mode     = FM_SAME;
    rand_cnt = 0;
    plan_idx = 0;
    density  = 3;
    break_at = 1;
    drained  = 1'b0;
    clear_frame();
    keyframe_on = 1'b1;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < DIR_ROWS; i++) begin
      send_word(dir_tab[i].word, dir_tab[i].start, 1'b1,
                '{dir_tab[i].want_data, dir_tab[i].want_nbytes,
                  dir_tab[i].want_kind, dir_tab[i].want_tail});
    end

    while (rand_cnt < RAND_ITEMS || frames_closed < MIN_FRAMES) begin
      quiet_span = (rand_cnt >= 60 && rand_cnt < 140);
      start = 1'b0;
      if (!keyframe_on && frame_pos == 0) begin
        if (!drained && rand_cnt >= 150) begin
          // Hold off the next frame until the encoder has emptied out.
          in_valid <= 1'b0;
          @(negedge clk_i);
          while (expected_q.size() != 0) @(negedge clk_i);
          drained = 1'b1;
        end
        if (plan_idx < 5) begin
          mode = plan[plan_idx];
          plan_idx++;
          density = 3;
        end else begin
          pick = $urandom_range(0, 15);
          case (pick)
            0, 1:    mode = FM_SAME;
            2:       mode = FM_FLIP;
            10, 11:  mode = FM_NOISE;
            12:      mode = FM_RESTART;
            13:      mode = FM_BROKEN;
            default: mode = FM_SPARSE;
          endcase
          density = $urandom_range(1, 64);
        end
        break_at = $urandom_range(1, FRAME_WORDS - 1);
        start = (mode == FM_RESTART);
      end else if (keyframe_on && frame_pos > 0) begin
        start = ($urandom_range(0, 63) == 0);
      end else if (!keyframe_on && mode == FM_BROKEN && frame_pos == break_at) begin
        start = 1'b1;
      end

      if (keyframe_on || start) begin
        word = rand_word();
      end else begin
        for (int b = 0; b < 8; b++) base[8 * b +: 8] = frame_bytes[frame_pos * 8 + b];
        word = base;
        case (mode)
          FM_FLIP:  word = ~base;
          FM_NOISE: word = rand_word();
          FM_SAME:  word = base;
          default: begin
            for (int b = 0; b < 8; b++) begin
              if ($urandom_range(0, 255) < density) begin
                word[8 * b +: 8] = base[8 * b +: 8] ^ 8'($urandom_range(1, 255));
              end
            end
          end
        endcase
      end
      send_word(word, start, 1'b0, '0);
      rand_cnt++;
    end

    quiet_span = 1'b0;
    in_valid <= 1'b0;
    wait_cycles = 0;
    while (expected_q.size() != 0 && wait_cycles < SETTLE_LIMIT) begin
      @(negedge clk_i);
      wait_cycles++;
    end
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (expected_q.size() != 0) begin
      note_fail($sformatf("%0d expected results never arrived", expected_q.size()));
    end
    if (fail_cnt == 0) begin
      $display("tb_frame_delta_mask_encoder: PASS");
    end else begin
      $display("tb_frame_delta_mask_encoder: FAIL");
    end
    $finish;
  end

endmodule
